/* src/rdc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants of the radix digit conversion block
// Holds the radix limits and the command and status groups that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rdc_pkg;

	localparam int RADIX_BITS = 6;
	localparam int DIGIT_BITS = 6;

	localparam logic [RADIX_BITS-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_BITS-1:0] RADIX_RESET = 6'd10;

	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic pop;
	} rdc_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic step_last;
		logic count_zero;
		logic out_free;
	} rdc_status_t;

endpackage

/* src/rdc_interfaces.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_interfaces: request, digit and configuration channels
// Each channel carries valid, ready and its payload, with a source and a sink
// modport.
// ----------------------------------------------------------------------------
interface rdc_req_if #(
	parameter int VALUE_BITS = 31
);
	logic                  valid;
	logic                  ready;
	logic [VALUE_BITS-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

interface rdc_digit_if;
	logic                           valid;
	logic                           ready;
	logic [rdc_pkg::DIGIT_BITS-1:0] digit;
	logic                           last_digit;

	modport source (output valid, output digit, output last_digit, input ready);
	modport sink (input valid, input digit, input last_digit, output ready);
endinterface

interface rdc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [rdc_pkg::RADIX_BITS-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* src/rdc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_ctrl: sequencer of the radix digit conversion block
// Steps through loading a request, the bit-serial divisions and the emission
// of the stacked digits.
// ----------------------------------------------------------------------------
module rdc_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  rdc_pkg::rdc_status_t status,
	output rdc_pkg::rdc_cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_DIV   = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		req_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.n_zero) begin
					state_d = ST_EMIT;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.step_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_EMIT: begin
				if (status.count_zero) begin
					state_d = ST_IDLE;
				end else if (status.out_free) begin
					cmd.pop = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_pop_needs_digits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> !status.count_zero && status.out_free)
		else $error("Pop issued without a stacked digit or a free output.");
	a_div_follows_check: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> cmd.div_step)
		else $error("Division start not followed by a division step.");
	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.div_step && !cmd.pop && !cmd.div_start)
		else $error("Load issued together with another command.");
`endif

endmodule

/* src/rdc_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_datapath: divider, digit stack and output register
// Holds the radix register, a restoring divider that takes one quotient bit
// per cycle, the digit memory and the registered output.
// ----------------------------------------------------------------------------
module rdc_datapath #(
	parameter int VALUE_BITS  = 31,
	parameter int DIGIT_DEPTH = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rdc_pkg::rdc_cmd_t              cmd,
	output rdc_pkg::rdc_status_t           status,
	input  logic [VALUE_BITS-1:0]          value,
	input  logic                           cfg_valid,
	input  logic [rdc_pkg::RADIX_BITS-1:0] cfg_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [rdc_pkg::DIGIT_BITS-1:0] out_digit,
	output logic                           out_last
);

	localparam int AW = $clog2(DIGIT_DEPTH);
	localparam int CW = $clog2(DIGIT_DEPTH + 1);
	localparam int BW = $clog2(VALUE_BITS);
	localparam int RB = rdc_pkg::RADIX_BITS;
	localparam int DB = rdc_pkg::DIGIT_BITS;

	logic [RB-1:0]         radix_q;
	logic [VALUE_BITS-1:0] n_q;
	logic [DB-1:0]         rem_q;
	logic [BW-1:0]         bit_cnt_q;
	logic [CW-1:0]         count_q;
	logic                  out_valid_q;
	logic [DB-1:0]         out_digit_q;
	logic                  out_last_q;
	logic [DB-1:0]         digit_mem [DIGIT_DEPTH];

	logic [DB:0]           rem_trial;
	logic                  rem_ge;
	logic [DB-1:0]         rem_new;
	logic [VALUE_BITS-1:0] n_new;
	logic [CW-1:0]         count_dec;
	logic                  push;
	logic [RB-1:0]         radix_sat;

	always_comb begin
		rem_trial = {rem_q, n_q[VALUE_BITS-1]};
		rem_ge    = rem_trial >= {1'b0, radix_q};
		rem_new   = rem_ge ? DB'(rem_trial - {1'b0, radix_q}) : rem_trial[DB-1:0];
		n_new     = {n_q[VALUE_BITS-2:0], rem_ge};
		count_dec = count_q - CW'(1);
		push      = cmd.div_step && status.step_last && (count_q < CW'(DIGIT_DEPTH));
	end

	always_comb begin
		priority if (cfg_data < rdc_pkg::RADIX_MIN) begin
			radix_sat = rdc_pkg::RADIX_MIN;
		end else if (cfg_data > rdc_pkg::RADIX_MAX) begin
			radix_sat = rdc_pkg::RADIX_MAX;
		end else begin
			radix_sat = cfg_data;
		end
	end

	assign status.n_zero     = (n_q == '0);
	assign status.step_last  = (bit_cnt_q == BW'(VALUE_BITS - 1));
	assign status.count_zero = (count_q == '0);
	assign status.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= rdc_pkg::RADIX_RESET;
			count_q     <= '0;
			bit_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				radix_q <= radix_sat;
			end
			if (cmd.load) begin
				count_q <= '0;
			end else if (push) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.pop) begin
				count_q <= count_dec;
			end
			if (cmd.div_start) begin
				bit_cnt_q <= '0;
			end else if (cmd.div_step) begin
				bit_cnt_q <= bit_cnt_q + BW'(1);
			end
			if (cmd.pop) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= value;
		end else if (cmd.div_step) begin
			n_q <= n_new;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_new;
		end
		if (cmd.pop) begin
			out_last_q <= (count_q == CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			digit_mem[count_q[AW-1:0]] <= rem_new;
		end
		if (cmd.pop) begin
			out_digit_q <= digit_mem[count_dec[AW-1:0]];
		end
	end

	assign out_valid = out_valid_q;
	assign out_digit = out_digit_q;
	assign out_last  = out_last_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DIGIT_DEPTH))
		else $error("Digit count exceeds the stack depth.");
	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> count_q == '0)
		else $error("Digit count not cleared by a load.");
	a_valid_from_pop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.pop))
		else $error("Output became valid without a pop.");
	a_remainder_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.div_step) |-> rem_q < radix_q)
		else $error("Division remainder not below the radix.");
`endif

endmodule

/* src/radix_digit_conversion_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_conversion_top: converts a value into digits of a set radix
// Top level joining the controller and the datapath to the request, digit
// and configuration channels.
// ----------------------------------------------------------------------------
// Each accepted request is divided by the radix repeatedly with a bit-serial
// restoring divider, one quotient bit per cycle; the digits are stacked and
// then sent most significant first at up to one digit per cycle, the final
// one flagged by last_digit, and a zero value gives no digits. A new request
// is taken once the previous digits have all been moved into the output
// register. Radix writes saturate into 2..36 and are always ready;
// they are meant to happen only while the block is idle.
module radix_digit_conversion_top #(
	parameter int VALUE_BITS  = 31,
	parameter int DIGIT_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	rdc_req_if.sink     req,
	rdc_digit_if.source rsp,
	rdc_cfg_if.sink     cfg
);

	rdc_pkg::rdc_cmd_t    cmd;
	rdc_pkg::rdc_status_t status;

	assign cfg.ready = 1'b1;

	rdc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rdc_datapath #(
		.VALUE_BITS  (VALUE_BITS),
		.DIGIT_DEPTH (DIGIT_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (req.value),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_digit (rsp.digit),
		.out_last  (rsp.last_digit)
	);

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the radix digit conversion block
// Drives values through the request channel under several radix settings and
// idle patterns. Every accepted value is converted to digits here, and each
// digit leaving the block is compared with the oldest digit still awaited.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int VALUE_BITS  = 31;
	localparam int DIGIT_DEPTH = 32;
	localparam int SETTLE_CYCLES = VALUE_BITS + 8;
	localparam int LONG_HOLD = 600;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [rdc_pkg::RADIX_BITS-1:0] radix_t;

	typedef struct packed {
		logic [rdc_pkg::DIGIT_BITS-1:0] digit;
		logic                           last_digit;
	} digit_t;

	logic clk = 1'b0;
	logic arst_n;

	rdc_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
	rdc_digit_if rsp_ch ();
	rdc_cfg_if cfg_ch ();

	radix_digit_conversion_top #(
		.VALUE_BITS (VALUE_BITS),
		.DIGIT_DEPTH(DIGIT_DEPTH)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch),
		.cfg   (cfg_ch)
	);

	always #2 clk = ~clk;

	value_t pending_values[$];
	digit_t awaited_digits[$];
	radix_t cur_radix = rdc_pkg::RADIX_RESET;

	int send_idle_pct = 0;
	int rcv_stall_pct = 0;
	int fail_count = 0;
	int values_taken = 0;
	int zero_values = 0;
	int digits_checked = 0;
	int radix_writes = 0;

	logic hold_arm = 1'b0;
	logic hold_taken = 1'b0;
	int hold_left = 0;
	digit_t head_digit;

	function automatic radix_t saturate_radix(input radix_t wdata);
		if (wdata < rdc_pkg::RADIX_MIN)
			return rdc_pkg::RADIX_MIN;
		if (wdata > rdc_pkg::RADIX_MAX)
			return rdc_pkg::RADIX_MAX;
		return wdata;
	endfunction

	function automatic void queue_digits(input value_t val);
		value_t n;
		logic [rdc_pkg::DIGIT_BITS-1:0] stack [DIGIT_DEPTH];
		int cnt;
		digit_t d;
		n = val;
		cnt = 0;
		while (n != 0) begin
			if (cnt < DIGIT_DEPTH) begin
				stack[cnt] = rdc_pkg::DIGIT_BITS'(n % cur_radix);
				cnt++;
			end
			n = n / cur_radix;
		end
		while (cnt > 0) begin
			cnt--;
			d.digit = stack[cnt];
			d.last_digit = (cnt == 0);
			awaited_digits.push_back(d);
		end
	endfunction

	function automatic value_t random_value();
		value_t v;
		case ($urandom_range(0, 7))
			0: v = value_t'($urandom_range(1, int'(cur_radix) * int'(cur_radix)));
			1: v = value_t'($urandom()) >> $urandom_range(0, VALUE_BITS - 1);
			2: v = $urandom_range(0, 1) ? '1 : '0;
			3: v = value_t'($urandom_range(0, 3));
			default: v = value_t'($urandom());
		endcase
		return v;
	endfunction

	// Request driver: holds an offered value until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.value <= '0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) begin
				queue_digits(req_ch.value);
				values_taken++;
				if (req_ch.value == '0)
					zero_values++;
				void'(pending_values.pop_front());
			end
			if (pending_values.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				req_ch.valid <= 1'b1;
				req_ch.value <= pending_values[0];
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// The long receiver hold-off is timed here, apart from the monitor.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_taken <= 1'b0;
		end else if (hold_arm && !hold_taken) begin
			hold_left <= LONG_HOLD;
			hold_taken <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Digit monitor and checker.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (awaited_digits.size() == 0) begin
					if (fail_count < 40)
						$display("%0t: unexpected digit: expected none, actual %0d last %b",
							$time, rsp_ch.digit, rsp_ch.last_digit);
					fail_count++;
				end else begin
					head_digit = awaited_digits.pop_front();
					digits_checked++;
					if (head_digit.digit !== rsp_ch.digit ||
						head_digit.last_digit !== rsp_ch.last_digit) begin
						if (fail_count < 40)
							$display("%0t: digit mismatch: expected %0d last %b, actual %0d last %b",
								$time, head_digit.digit, head_digit.last_digit,
								rsp_ch.digit, rsp_ch.last_digit);
						fail_count++;
					end
				end
			end
			rsp_ch.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= rcv_stall_pct);
		end
	end

	task automatic write_radix(input radix_t wdata);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= wdata;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		cur_radix = saturate_radix(wdata);
		radix_writes++;
	endtask

	task automatic wait_until_drained();
		do
			@(posedge clk);
		while (pending_values.size() != 0 || req_ch.valid);
		while (awaited_digits.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input radix_t wdata, input int send_pct, input int rcv_pct,
		input int count);
		write_radix(wdata);
		send_idle_pct = send_pct;
		rcv_stall_pct = rcv_pct;
		repeat (count) pending_values.push_back(random_value());
		wait_until_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.value = '0;
		rsp_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset radix of ten: zero, single digits, digit-count boundaries, full range.
		pending_values = '{0, 1, 9, 10, 99, 100, 1000000000, '1,
			31'h5555_5555, 31'h2AAA_AAAA, 31'h4000_0000};
		wait_until_drained();

		// Writes below the floor and above the ceiling saturate to two and 36.
		write_radix(radix_t'(0));
		pending_values = '{1, 2, 3, '1, 0};
		wait_until_drained();

		write_radix(radix_t'(63));
		pending_values = '{35, 36, 1295, 1296, '1, 0};
		wait_until_drained();

		random_phase(radix_t'(16), 0, 0, 15);
		random_phase(radix_t'($urandom_range(0, 63)), 80, 0, 15);

		// Digits are held back long enough for the block to stall its input.
		write_radix(radix_t'(7));
		send_idle_pct = 0;
		rcv_stall_pct = 80;
		@(posedge clk);
		hold_arm <= 1'b1;
		pending_values.push_back('1);
		repeat (19) pending_values.push_back(random_value());
		wait_until_drained();

		random_phase(radix_t'(36), 13, 13, 15);
		random_phase(radix_t'(37), 0, 80, 12);
		random_phase(radix_t'(2), 13, 13, 10);
		random_phase(radix_t'(1), 80, 0, 10);
		random_phase(radix_t'(10), 0, 0, 10);

		$display("Converted %0d values (%0d of them zero) into %0d checked digits.",
			values_taken, zero_values, digits_checked);
		$display("Used %0d radix writes over radix 2 to 36 with idle, stall and hold-off.",
			radix_writes);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
src/rdc_pkg.sv
src/rdc_interfaces.sv
src/rdc_ctrl.sv
src/rdc_datapath.sv
src/radix_digit_conversion_top.sv
verif/tb_top.sv
